[hdl/jps_pkg.sv]
// shared constants, codes and types of the 1d poisson jacobi sweeper
package jps_pkg;

  localparam int GRID_POINTS = 1024;
  localparam int IDX_W       = $clog2(GRID_POINTS);
  localparam int VALUE_W     = 32;
  localparam int H2_W        = 32;
  localparam int SWEEP_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // input tdata layout, lowest bit first
  localparam int IN_IDX_LSB  = 0;
  localparam int IN_U_LSB    = IDX_W;
  localparam int IN_F_LSB    = IDX_W + VALUE_W;
  localparam int IN_BITS     = IDX_W + 2 * VALUE_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_H_SQUARED   = 2'd2;

  localparam logic [IDX_W-1:0]   RST_LAST_INDEX  = IDX_W'(1023);
  localparam logic [SWEEP_W-1:0] RST_SWEEP_COUNT = SWEEP_W'(2);
  localparam logic [H2_W-1:0]    RST_H_SQUARED   = H2_W'(4096);

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_READ = 2'd2,
    ACT_NOP  = 2'd3
  } jps_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY0,
    ST_COPY1,
    ST_COPY2,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } jps_state_e;

  // one interior point entering the update pipeline
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] left;
    logic [VALUE_W-1:0] right;
    logic [VALUE_W-1:0] f;
  } jps_upd_req_t;

  // write-back leaving the update pipeline
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
    logic               sat;
  } jps_upd_wr_t;

  // result waiting for the output register
  typedef struct packed {
    logic valid;
    logic take_mem;
    logic status;
  } jps_pend_t;

endpackage

[hdl/jacobi_1d_poisson_sweeper.sv]
// top level of the 1d poisson jacobi sweeper: grid memories, sequencer and result path
// result path: a load, read or no-op result goes through the pending slot, then the output register
// throughput: load and read items stream at one per cycle while results are taken
// run: the boundary copy states, then 2 * ceil(sweeps/2) sweeps over the grid when there
//   is an interior, then the finish state and the result stage; input is blocked meanwhile
// reset: control, flag and configuration registers reset; grid memories undefined until written
module jacobi_1d_poisson_sweeper
  import jps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // index[9:0], u_value[41:10], f_value[73:42]
  input  logic [1:0]            s_axis_tuser,   // action[1:0]
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [VALUE_W-1:0]    m_axis_tdata,   // u_out[31:0]
  output logic [1:0]            m_axis_tuser,   // status[0], saturated[1]
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [IDX_W-1:0]   last_index_q;
  logic [SWEEP_W-1:0] sweep_count_q;
  logic [H2_W-1:0]    h_squared_q;

  // grid memories: solution, scratch and source
  logic [VALUE_W-1:0] sol_mem [GRID_POINTS];
  logic [VALUE_W-1:0] scr_mem [GRID_POINTS];
  logic [VALUE_W-1:0] src_mem [GRID_POINTS];

  logic               sol_we, scr_we, src_we;
  logic               sol_re, scr_re, src_re;
  logic [IDX_W-1:0]   sol_waddr, scr_waddr, sol_raddr, scr_raddr, src_raddr;
  logic [VALUE_W-1:0] sol_wdata, scr_wdata;
  logic [VALUE_W-1:0] sol_rdata_q, scr_rdata_q, src_rdata_q;

  // sequencer
  jps_state_e         state_q, state_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic               dir_q, dir_d;      // low: solution into scratch, high: back
  logic [SWEEP_W-1:0] pairs_q, pairs_d;
  logic [SWEEP_W:0]   pairs_inc;
  logic               sweep_issue;
  logic               copy_we;
  logic [IDX_W-1:0]   copy_addr;
  logic               fin_load;

  // read stage of a sweep
  logic               v1_q;
  logic [IDX_W-1:0]   k1_q;
  logic [VALUE_W-1:0] w1_q, w2_q;
  logic [VALUE_W-1:0] a_rd;

  jps_upd_req_t       upd_req;
  jps_upd_wr_t        upd_wr;
  logic               upd_busy;

  // result path
  jps_pend_t          pend_q, pend_d;
  logic               pend_move;
  logic               out_valid_q;
  logic [VALUE_W-1:0] out_data_q;
  logic               out_status_q;
  logic               out_sat_q;
  logic               sat_q;

  // input fields
  logic               acc;
  jps_action_e        act;
  logic [IDX_W-1:0]   in_idx;
  logic [VALUE_W-1:0] in_u, in_f;
  logic               in_range;
  logic               load_wr;

  assign act      = jps_action_e'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[IN_IDX_LSB +: IDX_W];
  assign in_u     = s_axis_tdata[IN_U_LSB +: VALUE_W];
  assign in_f     = s_axis_tdata[IN_F_LSB +: VALUE_W];
  assign in_range = in_idx <= last_index_q;

  // result register frees when taken; the pending slot moves into it
  assign pend_move     = pend_q.valid && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) && (!pend_q.valid || pend_move);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign load_wr       = acc && (act == ACT_LOAD) && in_range;

  // sweep pairs, rounded up
  assign pairs_inc = {1'b0, sweep_count_q} + (SWEEP_W+1)'(1);

  // configuration: always ready, writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_index_q  <= RST_LAST_INDEX;
      sweep_count_q <= RST_SWEEP_COUNT;
      h_squared_q   <= RST_H_SQUARED;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LAST_INDEX:  last_index_q  <= cfg_data_i[IDX_W-1:0];
        CFG_SWEEP_COUNT: sweep_count_q <= cfg_data_i[SWEEP_W-1:0];
        CFG_H_SQUARED:   h_squared_q   <= cfg_data_i[H2_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      dir_q   <= 1'b0;
      pairs_q <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      dir_q   <= dir_d;
      pairs_q <= pairs_d;
    end
  end

  // sequencer: next state and memory read requests
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    dir_d       = dir_q;
    pairs_d     = pairs_q;
    sol_re      = 1'b0;
    sol_raddr   = k_q;
    scr_re      = 1'b0;
    scr_raddr   = k_q;
    src_re      = 1'b0;
    src_raddr   = k_q - IDX_W'(1);    // source lags one behind the neighbour read
    sweep_issue = 1'b0;
    copy_we     = 1'b0;
    copy_addr   = '0;
    fin_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (act)
            ACT_READ: begin
              sol_re    = 1'b1;
              sol_raddr = in_idx;
            end
            ACT_RUN: begin
              pairs_d = pairs_inc[SWEEP_W:1];
              state_d = ST_COPY0;
            end
            default: ;
          endcase
        end
      end
      ST_COPY0: begin
        // fetch the lower boundary
        sol_re    = 1'b1;
        sol_raddr = '0;
        state_d   = ST_COPY1;
      end
      ST_COPY1: begin
        // lower boundary into scratch, fetch the upper one
        sol_re    = 1'b1;
        sol_raddr = last_index_q;
        copy_we   = 1'b1;
        copy_addr = '0;
        state_d   = ST_COPY2;
      end
      ST_COPY2: begin
        copy_we   = 1'b1;
        copy_addr = last_index_q;
        k_d       = '0;
        dir_d     = 1'b0;
        // no interior points or no pairs: the run is only the boundary copy
        if ((pairs_q != '0) && (last_index_q >= IDX_W'(2))) begin
          state_d = ST_SWEEP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SWEEP: begin
        sweep_issue = 1'b1;
        src_re      = 1'b1;
        if (dir_q) begin
          scr_re = 1'b1;
        end else begin
          sol_re = 1'b1;
        end
        if (k_q == last_index_q) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // the next sweep reads what this one writes: wait for the last write-back
        if (!v1_q && !upd_busy) begin
          k_d = '0;
          if (!dir_q) begin
            dir_d   = 1'b1;
            state_d = ST_SWEEP;
          end else if (pairs_q == SWEEP_W'(1)) begin
            state_d = ST_FINISH;
          end else begin
            pairs_d = pairs_q - SWEEP_W'(1);
            dir_d   = 1'b0;
            state_d = ST_SWEEP;
          end
        end
      end
      ST_FINISH: begin
        if (!pend_q.valid || pend_move) begin
          fin_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory write ports
  always_comb begin
    sol_we    = load_wr || (upd_wr.valid && dir_q);
    sol_waddr = upd_wr.valid ? upd_wr.idx : in_idx;
    sol_wdata = upd_wr.valid ? upd_wr.value : in_u;
    scr_we    = copy_we || (upd_wr.valid && !dir_q);
    scr_waddr = copy_we ? copy_addr : upd_wr.idx;
    scr_wdata = copy_we ? sol_rdata_q : upd_wr.value;
    src_we    = load_wr;
  end

  always_ff @(posedge clk_i) begin
    if (sol_we) begin
      sol_mem[sol_waddr] <= sol_wdata;
    end
    if (sol_re) begin
      sol_rdata_q <= sol_mem[sol_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    if (scr_re) begin
      scr_rdata_q <= scr_mem[scr_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[in_idx] <= in_f;
    end
    if (src_re) begin
      src_rdata_q <= src_mem[src_raddr];
    end
  end

  // read stage: a three-point window slides over the source grid of the sweep
  assign a_rd = dir_q ? scr_rdata_q : sol_rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= sweep_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q <= k_q;
    if (v1_q) begin
      w1_q <= a_rd;
      w2_q <= w1_q;
    end
  end

  // point k1-1 is ready once its right neighbour has arrived
  always_comb begin
    upd_req.valid = v1_q && (k1_q >= IDX_W'(2));
    upd_req.idx   = k1_q - IDX_W'(1);
    upd_req.left  = w2_q;
    upd_req.right = a_rd;
    upd_req.f     = src_rdata_q;
  end

  jps_update u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (upd_req),
    .h2_i   (h_squared_q),
    .wr_o   (upd_wr),
    .busy_o (upd_busy)
  );

  // saturation flag: cleared by each run, set by any saturated update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (acc && (act == ACT_RUN)) begin
      sat_q <= 1'b0;
    end else if (upd_wr.sat) begin
      sat_q <= 1'b1;
    end
  end

  // pending slot: holds a result while its read data arrives, then moves to the output
  always_comb begin
    pend_d = pend_q;
    if (pend_move) begin
      pend_d.valid = 1'b0;
    end
    if (acc) begin
      case (act)
        ACT_READ: begin
          pend_d.valid    = 1'b1;
          pend_d.take_mem = in_range;
          pend_d.status   = !in_range;
        end
        ACT_LOAD: begin
          pend_d.valid    = 1'b1;
          pend_d.take_mem = 1'b0;
          pend_d.status   = !in_range;
        end
        ACT_NOP: begin
          pend_d.valid    = 1'b1;
          pend_d.take_mem = 1'b0;
          pend_d.status   = 1'b0;
        end
        default: ;
      endcase
    end
    if (fin_load) begin
      pend_d.valid    = 1'b1;
      pend_d.take_mem = 1'b0;
      pend_d.status   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      out_data_q   <= pend_q.take_mem ? sol_rdata_q : '0;
      out_status_q <= pend_q.status;
      out_sat_q    <= sat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_sat_q, out_status_q};

endmodule

[hdl/jps_update.sv]
// point update: h2*f product and neighbour sum registered, then halving and saturation
module jps_update
  import jps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jps_upd_req_t       req_i,
  input  logic [H2_W-1:0]    h2_i,
  output jps_upd_wr_t        wr_o,
  output logic               busy_o
);

  logic signed [VALUE_W+H2_W-1:0] prod_full;
  logic        [VALUE_W+H2_W-1:0] prod_q;
  logic        [VALUE_W:0]        lr_q;
  logic        [IDX_W-1:0]        idx_q;
  logic                           va_q;
  logic        [VALUE_W-1:0]      term;
  logic        [VALUE_W+1:0]      sum;
  logic        [VALUE_W:0]        half;
  logic                           ovf;

  assign prod_full = $signed(req_i.f) * $signed({1'b0, h2_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full;
    lr_q   <= {req_i.left[VALUE_W-1], req_i.left} + {req_i.right[VALUE_W-1], req_i.right};
    idx_q  <= req_i.idx;
  end

  // floor of the product back to q8.24, then floor of the sum by two
  assign term = prod_q[VALUE_W+H2_W-1:H2_W];
  assign sum  = {lr_q[VALUE_W], lr_q} + {{2{term[VALUE_W-1]}}, term};
  assign half = sum[VALUE_W+1:1];
  assign ovf  = half[VALUE_W] != half[VALUE_W-1];

  always_comb begin
    wr_o.valid = va_q;
    wr_o.idx   = idx_q;
    wr_o.sat   = va_q && ovf;
    if (ovf) begin
      wr_o.value = half[VALUE_W] ? VALUE_MIN : VALUE_MAX;
    end else begin
      wr_o.value = half[VALUE_W-1:0];
    end
  end

  assign busy_o = va_q;

endmodule

[hdl/jps_checker.sv]
// port-level checks of the sweeper, bound to the top level
module jps_checker
  import jps_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [1:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [VALUE_W-1:0]    m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a run transaction blocks the input while the grid is swept
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_RUN) |=> !s_axis_tready)
    else $error("input accepted right after a run");

  // an out-of-range index never returns grid data
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("out-of-range result carries data");

  // a short item accepted while the output is free or taken shows up as a valid result
  a_short_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_RUN) &&
      (!m_axis_tvalid || m_axis_tready) |=> ##1 m_axis_tvalid)
    else $error("result of a short item late");

endmodule

bind jacobi_1d_poisson_sweeper jps_checker u_jps_checker (.*);
